[src/cpt_pkg.sv]
// ----------------------------------------------------------------------------
// Clarke/Park transform package
// Shared widths, constants, the quarter-wave sine table and the records that
// pass between the pipeline sections.
// ----------------------------------------------------------------------------
`default_nettype none

package cpt_pkg;

  localparam int ANGLE_BITS   = 10;
  localparam int SAMPLE_WIDTH = 16;

  // Sine and cosine are Q1.15 regardless of the sample width.
  localparam int TRIG_W    = 16;
  localparam int Q_FRAC    = 15;
  localparam int OUT_SHIFT = 2 * Q_FRAC;

  // u + 2v needs two extra bits; (u + 2v) / sqrt3 stays below 2^(SW+15).
  localparam int Y0_W  = SAMPLE_WIDTH + 2;
  localparam int Y_W   = SAMPLE_WIDTH + 16;
  localparam int PX_W  = SAMPLE_WIDTH + TRIG_W;
  localparam int ACC_W = Y_W + TRIG_W;
  localparam int RND_W = ACC_W - OUT_SHIFT;

  localparam int QTR_BITS  = ANGLE_BITS - 2;
  localparam int QTR_STEPS = 1 << QTR_BITS;

  localparam int IN_DATA_W  = ((2 * SAMPLE_WIDTH + ANGLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * SAMPLE_WIDTH + 7) / 8) * 8;

  localparam logic signed [TRIG_W-1:0] INV_SQRT3_Q15  = 16'sd18919;
  localparam logic signed [TRIG_W-1:0] HALF_SQRT3_Q15 = 16'sd28378;

  typedef enum logic {
    FUNC_FWD = 1'b0,
    FUNC_INV = 1'b1
  } func_t;

  // Q30 coefficients of sin(pi/2 * x) on x in [0, 1].
  localparam longint PC1 = 64'sd1686629713;
  localparam longint PC3 = 64'sd693598668;
  localparam longint PC5 = 64'sd85569306;
  localparam longint PC7 = 64'sd5026995;
  localparam longint PC9 = 64'sd172273;

  typedef logic [TRIG_W-2:0] qmag_t;
  typedef qmag_t qtab_t [QTR_STEPS];

  // Evaluated at elaboration only, to fill the constant table.
  function automatic longint quarter_sin(input int k);
    longint x;
    longint x2;
    longint p;
    longint s;
    x  = longint'(k) <<< (30 - QTR_BITS);
    x2 = (x * x) >>> 30;
    p  = PC9;
    p  = PC7 - ((x2 * p) >>> 30);
    p  = PC5 - ((x2 * p) >>> 30);
    p  = PC3 - ((x2 * p) >>> 30);
    p  = PC1 - ((x2 * p) >>> 30);
    s  = (x * p) >>> 30;
    s  = (s + 64'sd16384) >>> 15;
    if (s > 64'sd32767) begin
      s = 64'sd32767;
    end
    return s;
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int k = 0; k < QTR_STEPS; k++) begin
      t[k] = qmag_t'(quarter_sin(k));
    end
    return t;
  endfunction

  localparam qtab_t QSIN_TAB  = build_qtab();
  localparam qmag_t QSIN_PEAK = qmag_t'(quarter_sin(QTR_STEPS));

  // Full-turn sine from the quarter table; odd quadrants read mirrored, and
  // the mirrored read of index zero is the peak that the table does not hold.
  function automatic logic signed [TRIG_W-1:0] rom_sin(input logic [ANGLE_BITS-1:0] a);
    logic [1:0]          quad;
    logic [QTR_BITS-1:0] k;
    logic [QTR_BITS-1:0] idx;
    qmag_t               mag;
    quad = a[ANGLE_BITS-1 -: 2];
    k    = a[QTR_BITS-1:0];
    idx  = quad[0] ? (QTR_BITS'(0) - k) : k;
    if (quad[0] && (k == '0)) begin
      mag = QSIN_PEAK;
    end else begin
      mag = QSIN_TAB[idx];
    end
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  typedef struct packed {
    func_t                          func;
    logic signed [SAMPLE_WIDTH-1:0] x;
    logic signed [Y0_W-1:0]         y0;
    logic signed [TRIG_W-1:0]       sin_val;
    logic signed [TRIG_W-1:0]       cos_val;
  } trig_t;

  typedef struct packed {
    func_t                   func;
    logic signed [ACC_W-1:0] r1;
    logic signed [ACC_W-1:0] r2;
  } rot_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc0;
    logic signed [ACC_W-1:0] acc1;
    logic signed [ACC_W-1:0] acc2;
  } acc_t;

endpackage

`default_nettype wire

[src/cpt_trig.sv]
// ----------------------------------------------------------------------------
// Angle lookup stage
// Reads sine and cosine from the quarter-wave table and forms u + 2v on the forward path.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_trig (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  cpt_pkg::func_t                         func,
  input  logic signed [cpt_pkg::SAMPLE_WIDTH-1:0] in_first,
  input  logic signed [cpt_pkg::SAMPLE_WIDTH-1:0] in_second,
  input  logic [cpt_pkg::ANGLE_BITS-1:0]          angle,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output cpt_pkg::trig_t                         out_data
);
  import cpt_pkg::*;

  logic  en;
  trig_t data_next;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    data_next.func    = func;
    data_next.x       = in_first;
    data_next.y0      = (func == FUNC_FWD) ?
                        Y0_W'(in_first) + (Y0_W'(in_second) <<< 1) : Y0_W'(in_second);
    data_next.sin_val = rom_sin(angle);
    data_next.cos_val = rom_sin(angle + ANGLE_BITS'(QTR_STEPS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

[src/cpt_rotate.sv]
// ----------------------------------------------------------------------------
// Rotation section
// Scales by 1/sqrt3 on the forward path, forms the four products and sums
// them into the rotated pair. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_rotate (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cpt_pkg::trig_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cpt_pkg::rot_t  out_data
);
  import cpt_pkg::*;

  logic va, vb;
  logic en_a, en_b, en_c;

  func_t                          a_func;
  logic signed [SAMPLE_WIDTH-1:0] a_x;
  logic signed [Y_W-1:0]          a_y;
  logic signed [TRIG_W-1:0]       a_sin;
  logic signed [TRIG_W-1:0]       a_cos;

  func_t                   b_func;
  logic signed [PX_W-1:0]  b_p1, b_p4;
  logic signed [ACC_W-1:0] b_p2, b_p3;

  logic signed [ACC_W-1:0] p1e, p4e;
  rot_t                    rot_next;

  assign en_c     = !out_valid || out_ready;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) va        <= in_valid;
      if (en_b) vb        <= va;
      if (en_c) out_valid <= vb;
    end
  end

  // Stage a: the forward path divides u + 2v by sqrt3.
  always_ff @(posedge clk) begin
    if (en_a) begin
      a_func <= in_data.func;
      a_x    <= in_data.x;
      a_y    <= (in_data.func == FUNC_FWD) ?
                Y_W'(in_data.y0) * Y_W'(INV_SQRT3_Q15) : Y_W'(in_data.y0);
      a_sin  <= in_data.sin_val;
      a_cos  <= in_data.cos_val;
    end
  end

  // Stage b: the four rotation products.
  always_ff @(posedge clk) begin
    if (en_b) begin
      b_func <= a_func;
      b_p1   <= PX_W'(a_x) * PX_W'(a_cos);
      b_p4   <= PX_W'(a_x) * PX_W'(a_sin);
      b_p2   <= ACC_W'(a_y) * ACC_W'(a_sin);
      b_p3   <= ACC_W'(a_y) * ACC_W'(a_cos);
    end
  end

  // Stage c: forward keeps u at Q15 so its products move up by 15 bits.
  always_comb begin
    p1e           = ACC_W'(b_p1);
    p4e           = ACC_W'(b_p4);
    rot_next.func = b_func;
    unique case (b_func)
      FUNC_FWD: begin
        rot_next.r1 = (p1e <<< Q_FRAC) + b_p2;
        rot_next.r2 = b_p3 - (p4e <<< Q_FRAC);
      end
      FUNC_INV: begin
        rot_next.r1 = p1e - b_p2;
        rot_next.r2 = b_p3 + p4e;
      end
      default: begin
        rot_next.r1 = '0;
        rot_next.r2 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      out_data <= rot_next;
    end
  end

endmodule

`default_nettype wire

[src/cpt_clarke.sv]
// ----------------------------------------------------------------------------
// Inverse Clarke section
// Builds the three phase accumulators on the inverse path and passes the
// rotated pair through on the forward path. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_clarke (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cpt_pkg::rot_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cpt_pkg::acc_t out_data
);
  import cpt_pkg::*;

  logic vd;
  logic en_d, en_e;

  func_t                   d_func;
  logic signed [ACC_W-1:0] d_a;
  logic signed [ACC_W-1:0] d_b;

  logic signed [ACC_W-1:0] a_sh15, a_sh14;
  acc_t                    acc_next;

  assign en_e     = !out_valid || out_ready;
  assign en_d     = !vd || en_e;
  assign in_ready = en_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_d) vd        <= in_valid;
      if (en_e) out_valid <= vd;
    end
  end

  // On the inverse path beta fits in Y_W bits, which keeps the multiply narrow.
  always_ff @(posedge clk) begin
    if (en_d) begin
      d_func <= in_data.func;
      d_a    <= in_data.r1;
      d_b    <= (in_data.func == FUNC_INV) ?
                ACC_W'($signed(in_data.r2[Y_W-1:0])) * ACC_W'(HALF_SQRT3_Q15) :
                in_data.r2;
    end
  end

  always_comb begin
    a_sh15 = d_a <<< Q_FRAC;
    a_sh14 = d_a <<< (Q_FRAC - 1);
    unique case (d_func)
      FUNC_INV: begin
        acc_next.acc0 = a_sh15;
        acc_next.acc1 = d_b - a_sh14;
        acc_next.acc2 = -a_sh14 - d_b;
      end
      FUNC_FWD: begin
        acc_next.acc0 = d_a;
        acc_next.acc1 = d_b;
        acc_next.acc2 = '0;
      end
      default: begin
        acc_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      out_data <= acc_next;
    end
  end

endmodule

`default_nettype wire

[src/cpt_round.sv]
// ----------------------------------------------------------------------------
// Output stage
// Rounds each accumulator half up from Q30 and saturates it to a sample.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_round (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  cpt_pkg::acc_t                           in_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [cpt_pkg::SAMPLE_WIDTH-1:0] out_first,
  output logic signed [cpt_pkg::SAMPLE_WIDTH-1:0] out_second,
  output logic signed [cpt_pkg::SAMPLE_WIDTH-1:0] out_third
);
  import cpt_pkg::*;

  localparam logic signed [ACC_W-1:0] RND_HALF =
    ACC_W'(longint'(1) <<< (OUT_SHIFT - 1));
  localparam logic signed [RND_W-1:0] Q_MAX =
    RND_W'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - longint'(1));
  localparam logic signed [RND_W-1:0] Q_MIN =
    RND_W'(-(longint'(1) <<< (SAMPLE_WIDTH - 1)));

  function automatic logic signed [SAMPLE_WIDTH-1:0] finish(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] r;
    logic signed [RND_W-1:0] q;
    r = acc + RND_HALF;
    q = $signed(r[ACC_W-1:OUT_SHIFT]);
    if (q > Q_MAX) begin
      q = Q_MAX;
    end else if (q < Q_MIN) begin
      q = Q_MIN;
    end
    return SAMPLE_WIDTH'(q);
  endfunction

  logic en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_first  <= finish(in_data.acc0);
      out_second <= finish(in_data.acc1);
      out_third  <= finish(in_data.acc2);
    end
  end

endmodule

`default_nettype wire

[src/clarke_park_transform.sv]
// ----------------------------------------------------------------------------
// Clarke/Park frame transform
// Forward uvw to dq and inverse dq to uvw for field-oriented control.
// ----------------------------------------------------------------------------
// Each request on the input stream carries two Q1.15 samples, an electrical
// angle (a full turn is 2^ANGLE_BITS steps and the angle wraps) and a
// direction in tuser, and gives exactly one result request. The datapath is
// a seven-stage pipeline: one stage of sine and cosine lookup, three of
// rotation (1/sqrt3 scaling, four products, sums), two of inverse Clarke
// (sqrt3/2 product, phase sums) and one of rounding and saturation that is
// also the output register. It takes one request per clock while the output
// is not stalled. Every stage carries its own valid bit and loads whenever
// it is empty or the stage after it moves, so a stall at the output holds
// the results in place and empty stages still fill from the input. There is
// no kept state and no configuration.
`default_nettype none

module clarke_park_transform (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // in_first [15:0], in_second [31:16], angle [41:32], zero fill above
  input  logic [cpt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func: 0 forward, 1 inverse
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_first [15:0], out_second [31:16], out_third [47:32]
  output logic [cpt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import cpt_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] in_first, in_second;
  logic [ANGLE_BITS-1:0]          angle;
  logic signed [SAMPLE_WIDTH-1:0] out_first, out_second, out_third;

  logic  trig_valid, trig_ready;
  trig_t trig_data;
  logic  rot_valid, rot_ready;
  rot_t  rot_data;
  logic  acc_valid, acc_ready;
  acc_t  acc_data;

  assign in_first  = $signed(s_axis_tdata[SAMPLE_WIDTH-1:0]);
  assign in_second = $signed(s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
  assign angle     = s_axis_tdata[2*SAMPLE_WIDTH +: ANGLE_BITS];

  cpt_trig u_trig (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .func      (func_t'(s_axis_tuser)),
    .in_first  (in_first),
    .in_second (in_second),
    .angle     (angle),
    .out_valid (trig_valid),
    .out_ready (trig_ready),
    .out_data  (trig_data)
  );

  cpt_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (trig_valid),
    .in_ready  (trig_ready),
    .in_data   (trig_data),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_data  (rot_data)
  );

  cpt_clarke u_clarke (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_data   (rot_data),
    .out_valid (acc_valid),
    .out_ready (acc_ready),
    .out_data  (acc_data)
  );

  cpt_round u_round (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (acc_valid),
    .in_ready   (acc_ready),
    .in_data    (acc_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_first  (out_first),
    .out_second (out_second),
    .out_third  (out_third)
  );

  // The result fields are packed from the lowest bit up with zero fill.
  always_comb begin
    m_axis_tdata                                  = '0;
    m_axis_tdata[SAMPLE_WIDTH-1:0]                = out_first;
    m_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]   = out_second;
    m_axis_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH] = out_third;
  end

endmodule

`default_nettype wire

[src/cpt_checker.sv]
// ----------------------------------------------------------------------------
// Clarke/Park transform port checker
// Watches the stream ports of the transform for reset, stall and latency.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [cpt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or was dropped");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while the output can move");

  // Seven pipeline stages: with the output taking results, an accepted request
  // passes through every stage and shows up as a result.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
      |=> m_axis_tvalid)
    else $error("accepted request did not reach the output in time");

endmodule

bind clarke_park_transform cpt_checker u_cpt_checker (.*);

`default_nettype wire
